// ===== src/pm_pkg.sv =====
// Shared widths, defaults and cell control type for the polynomial multiplier.
`default_nettype none

package pm_pkg;

    localparam int COEF_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int DEG_W           = 6;
    localparam int MAX_TERMS_DEF   = 32;

    typedef struct packed {
        logic adv;
        logic clr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== src/pm_ifs.sv =====
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface pm_in_if;
    import pm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;

    modport source (output valid, output operation, output coefficient, output last,
                    input ready);
    modport sink   (input valid, input operation, input coefficient, input last,
                    output ready);
endinterface

interface pm_out_if;
    import pm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] product_coefficient;
    logic        [DEG_W-1:0]  degree;
    logic                     saturated;
    logic                     dropped;
    logic                     final_res;

    modport source (output valid, output product_coefficient, output degree,
                    output saturated, output dropped, output final_res, input ready);
    modport sink   (input valid, input product_coefficient, input degree,
                    input saturated, input dropped, input final_res, output ready);
endinterface

`default_nettype wire

// ===== src/polynomial_multiply.sv =====
// Top level: coefficient loading, second store, convolution cell chain, result stage.
//
//  channel | dir | word fields                                                  | handshake
//  i_in    | in  | operation, coefficient, last                                 | valid/ready
//  o_out   | out | product_coefficient, degree, saturated, dropped, final_res   | valid/ready
//
// Loading takes one word per cycle. The word that ends the second polynomial starts a run
// of n1+n2-1 results, streamed one per cycle while o_out is not stalled, through the cell
// chain stages store read, multiply, chain add and saturate; no word is taken during a run.
// Synchronous active-low reset clears counts, flags and the sequencer; stores are not cleared.
// A stall on o_out freezes the whole chain until the result is taken.
`default_nettype none

module polynomial_multiply #(
    parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    pm_in_if.sink   i_in,
    pm_out_if.source o_out
);
    import pm_pkg::*;

    localparam int PROD_W = 2 * COEF_W;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TERMS) + 1;
    localparam int SH_W   = SUM_W - FRAC_W;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W = $clog2(MAX_TERMS);
    localparam int T_W    = $clog2(2 * MAX_TERMS);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_first_count, n_first_count;
    logic [CNT_W-1:0] r_second_count, n_second_count;
    logic             r_first_done, n_first_done;
    logic             r_ovf, n_ovf;
    logic [T_W-1:0]   r_t, n_t;

    logic signed [COEF_W-1:0] r_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] r_rd;

    logic             r_fv, r_pv, r_sv;
    logic             r_fzero;
    logic [DEG_W-1:0] r_fdeg, r_pdeg, r_sdeg;
    logic             r_ffin, r_pfin, r_sfin;

    logic                     r_out_valid;
    logic signed [COEF_W-1:0] r_out_coef;
    logic [DEG_W-1:0]         r_out_deg;
    logic                     r_out_sat;
    logic                     r_out_fin;

    logic             w_acc;
    logic             w_adv;
    logic [CNT_W-1:0] w_base;
    logic [T_W-1:0]   w_last_t;
    logic [CNT_W-1:0] w_n1;
    t_cell_ctrl       w_ctrl;
    logic [MAX_TERMS-1:0] w_we;
    logic [MAX_TERMS-1:0] w_act;
    logic signed [COEF_W-1:0] w_x;
    logic signed [SUM_W-1:0]  w_sum [MAX_TERMS+1];
    logic signed [SH_W-1:0]   w_sh;
    logic                     w_pos_sat;
    logic                     w_neg_sat;

    assign i_in.ready = (r_state == ST_LOAD);
    assign w_acc      = i_in.valid && (r_state == ST_LOAD);
    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_base     = r_first_done ? '0 : r_first_count;

    // an empty first store counts as the single coefficient zero
    assign w_n1     = (r_first_count == '0) ? CNT_W'(1) : r_first_count;
    assign w_last_t = T_W'(w_n1) + T_W'(r_second_count) - T_W'(2);

    assign w_ctrl.adv = w_adv;
    assign w_ctrl.clr = w_acc && i_in.operation && i_in.last;

    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_first_done   = r_first_done;
        n_ovf          = r_ovf;
        n_t            = r_t;
        case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    if (!i_in.operation) begin
                        if (w_base < CNT_W'(MAX_TERMS)) begin
                            n_first_count = w_base + CNT_W'(1);
                        end else begin
                            n_first_count = w_base;
                            n_ovf         = 1'b1;
                        end
                        n_first_done = i_in.last;
                    end else begin
                        if (r_second_count < CNT_W'(MAX_TERMS)) begin
                            n_second_count = r_second_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_in.last) begin
                            n_state = ST_RUN;
                            n_t     = '0;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    n_t = r_t + T_W'(1);
                    if (r_t == w_last_t) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (r_out_valid && o_out.ready && r_out_fin) begin
                    n_state        = ST_LOAD;
                    n_first_count  = '0;
                    n_second_count = '0;
                    n_first_done   = 1'b0;
                    n_ovf          = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_done   <= 1'b0;
            r_ovf          <= 1'b0;
            r_t            <= '0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_first_done   <= n_first_done;
            r_ovf          <= n_ovf;
            r_t            <= n_t;
        end
    end

    // second store
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.operation && (r_second_count < CNT_W'(MAX_TERMS))) begin
            r_mem[r_second_count[ADDR_W-1:0]] <= i_in.coefficient;
        end
        if (w_adv) begin
            r_rd <= r_mem[r_t[ADDR_W-1:0]];
        end
    end

    // feed stage tags; reads past the second count feed zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= (r_state == ST_RUN);
            r_pv <= r_fv;
            r_sv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fzero <= (r_t >= T_W'(r_second_count));
            r_fdeg  <= DEG_W'(r_t);
            r_ffin  <= (r_t == w_last_t);
            r_pdeg  <= r_fdeg;
            r_pfin  <= r_ffin;
            r_sdeg  <= r_pdeg;
            r_sfin  <= r_pfin;
        end
    end

    assign w_x = (r_fv && !r_fzero) ? r_rd : '0;

    assign w_sum[MAX_TERMS] = '0;

    for (genvar gi = 0; gi < MAX_TERMS; gi++) begin : g_cell
        assign w_we[gi]  = w_acc && !i_in.operation && (w_base == CNT_W'(gi));
        assign w_act[gi] = (CNT_W'(gi) < r_first_count);

        pm_cell #(
            .MAX_TERMS (MAX_TERMS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_we   (w_we[gi]),
            .i_act  (w_act[gi]),
            .i_coef (i_in.coefficient),
            .i_x    (w_x),
            .i_sum  (w_sum[gi+1]),
            .o_sum  (w_sum[gi])
        );
    end

    // floor shift is the part-select; clip when the upper bits disagree with the sign
    assign w_sh      = w_sum[0][SUM_W-1:FRAC_W];
    assign w_pos_sat = !w_sh[SH_W-1] && (|w_sh[SH_W-1:COEF_W-1]);
    assign w_neg_sat = w_sh[SH_W-1] && !(&w_sh[SH_W-1:COEF_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_pos_sat) begin
                r_out_coef <= {1'b0, {(COEF_W-1){1'b1}}};
            end else if (w_neg_sat) begin
                r_out_coef <= {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                r_out_coef <= w_sh[COEF_W-1:0];
            end
            r_out_sat <= w_pos_sat || w_neg_sat;
            r_out_deg <= r_sdeg;
            r_out_fin <= r_sfin;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.product_coefficient = r_out_coef;
    assign o_out.degree              = r_out_deg;
    assign o_out.saturated           = r_out_sat;
    assign o_out.dropped             = r_ovf;
    assign o_out.final_res           = r_out_fin;

endmodule

`default_nettype wire

// ===== src/pm_cell.sv =====
// One tap of the transposed convolution chain: holds a first-polynomial coefficient.
`default_nettype none

module pm_cell #(
    parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF
) (
    input  wire                                    i_clk,
    input  wire pm_pkg::t_cell_ctrl                i_ctrl,
    input  wire                                    i_we,
    input  wire                                    i_act,
    input  wire signed [pm_pkg::COEF_W-1:0]        i_coef,
    input  wire signed [pm_pkg::COEF_W-1:0]        i_x,
    input  wire signed [2*pm_pkg::COEF_W+$clog2(MAX_TERMS):0] i_sum,
    output logic signed [2*pm_pkg::COEF_W+$clog2(MAX_TERMS):0] o_sum
);
    import pm_pkg::*;

    localparam int PROD_W = 2 * COEF_W;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TERMS) + 1;

    logic signed [COEF_W-1:0] r_a;
    logic signed [PROD_W-1:0] r_p;
    logic signed [SUM_W-1:0]  r_s;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_a <= i_coef;
        end
    end

    // multiply, then add the neighbor's partial sum one stage later
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_p <= '0;
            r_s <= '0;
        end else if (i_ctrl.adv) begin
            r_p <= i_act ? PROD_W'(r_a * i_x) : '0;
            r_s <= i_sum + SUM_W'(r_p);
        end
    end

    assign o_sum = r_s;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for polynomial_multiply: random coefficient streams against a product predictor.

module tb;
    import pm_pkg::*;

    localparam logic OP_FIRST    = 1'b0;
    localparam logic OP_SECOND   = 1'b1;
    localparam int   CAPACITY    = MAX_TERMS_DEF;
    localparam int   RANDOM_WORDS = 390;
    localparam int   QUIET_LIMIT = 4000;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   PHASE_WORDS = 40;

    localparam logic signed [79:0] Q_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] Q_MIN = -80'sh8000_0000;

    typedef struct {
        logic              op;
        logic [COEF_W-1:0] coef;
        logic              last;
    } coef_word_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [DEG_W-1:0]  degree;
        logic              saturated;
        logic              dropped;
        logic              final_res;
    } product_term_t;

    logic clk;
    logic rst_n;

    pm_in_if  in_bus ();
    pm_out_if out_bus ();

    polynomial_multiply u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    coef_word_t    pending_words[$];
    product_term_t expected_terms[$];

    // predictor state
    logic signed [COEF_W-1:0] first_poly  [CAPACITY];
    logic signed [COEF_W-1:0] second_poly [CAPACITY];
    int   first_len;
    int   second_len;
    logic first_closed;
    logic lost_terms;

    int   words_taken;
    int   bad_results;
    int   quiet_cycles;

    coef_word_t    next_word;
    product_term_t got_term;
    product_term_t want_term;

    always #5 clk = ~clk;

    // 0: no idling, 1: sender idle, 2: receiver stall, 3: both light
    function automatic int idle_pct(input logic sender);
        case ((words_taken / PHASE_WORDS) % 4)
            1: return sender ? 75 : 0;
            2: return sender ? 0 : 75;
            3: return 9;
            default: return 0;
        endcase
    endfunction

    // Fold one accepted word into the predictor; a closing second word yields the product.
    task automatic absorb_word(input logic op, input logic [COEF_W-1:0] coef, input logic last);
        int n1;
        int n2;
        int total;
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        product_term_t t;
        if (op == OP_FIRST) begin
            if (first_closed) begin
                first_len    = 0;
                first_closed = 1'b0;
            end
            if (first_len < CAPACITY) begin
                first_poly[first_len] = coef;
                first_len++;
            end else begin
                lost_terms = 1'b1;
            end
            if (last) first_closed = 1'b1;
        end else begin
            if (second_len < CAPACITY) begin
                second_poly[second_len] = coef;
                second_len++;
            end else begin
                lost_terms = 1'b1;
            end
            if (last) begin
                n1 = first_len;
                // empty first polynomial counts as the zero constant
                if (n1 == 0) begin
                    first_poly[0] = '0;
                    n1 = 1;
                end
                n2    = second_len;
                total = n1 + n2 - 1;
                for (int d = 0; d < total; d++) begin
                    acc = '0;
                    for (int i = 0; i < n1; i++) begin
                        if (i <= d && d - i < n2)
                            acc = acc + first_poly[i] * second_poly[d - i];
                    end
                    shifted = acc >>> FRAC_W;
                    if (shifted > Q_MAX) begin
                        t.coef      = 32'h7FFF_FFFF;
                        t.saturated = 1'b1;
                    end else if (shifted < Q_MIN) begin
                        t.coef      = 32'h8000_0000;
                        t.saturated = 1'b1;
                    end else begin
                        t.coef      = shifted[COEF_W-1:0];
                        t.saturated = 1'b0;
                    end
                    t.degree    = DEG_W'(d);
                    t.dropped   = lost_terms;
                    t.final_res = (d == total - 1);
                    expected_terms.push_back(t);
                end
                first_len    = 0;
                second_len   = 0;
                first_closed = 1'b0;
                lost_terms   = 1'b0;
            end
        end
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r;
            1: return {{8{r[23]}}, r[23:0]};
            2: return {{14{r[17]}}, r[17:0]};
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0001_0000;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic int rand_len();
        if ($urandom_range(99) < 8) return $urandom_range(CAPACITY + 3, CAPACITY - 3);
        return $urandom_range(6, 1);
    endfunction

    task automatic push_word(input logic op, input logic [COEF_W-1:0] coef, input logic last);
        coef_word_t w;
        w.op   = op;
        w.coef = coef;
        w.last = last;
        pending_words.push_back(w);
    endtask

    // n random coefficients; close marks the top one as last
    task automatic push_poly(input logic op, input int n, input logic close);
        for (int k = 0; k < n; k++)
            push_word(op, rand_coef(), close && (k == n - 1));
    endtask

    // Driver: advance to the next word once the current one is taken or none is up.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                absorb_word(in_bus.operation, in_bus.coefficient, in_bus.last);
                words_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    next_word = pending_words.pop_front();
                    in_bus.valid       <= 1'b1;
                    in_bus.operation   <= next_word.op;
                    in_bus.coefficient <= next_word.coef;
                    in_bus.last        <= next_word.last;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest expected term.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_term.coef      = out_bus.product_coefficient;
                got_term.degree    = out_bus.degree;
                got_term.saturated = out_bus.saturated;
                got_term.dropped   = out_bus.dropped;
                got_term.final_res = out_bus.final_res;
                if (expected_terms.size() == 0) begin
                    $display("%0t: unexpected word: coef %h degree %0d sat %b drop %b final %b",
                             $time, got_term.coef, got_term.degree, got_term.saturated,
                             got_term.dropped, got_term.final_res);
                    bad_results++;
                end else begin
                    want_term = expected_terms.pop_front();
                    if (got_term != want_term) begin
                        $display("%0t: expected coef %h degree %0d sat %b drop %b final %b",
                                 $time, want_term.coef, want_term.degree, want_term.saturated,
                                 want_term.dropped, want_term.final_res);
                        $display("%0t:   actual coef %h degree %0d sat %b drop %b final %b",
                                 $time, got_term.coef, got_term.degree, got_term.saturated,
                                 got_term.dropped, got_term.final_res);
                        bad_results++;
                    end
                end
            end
            out_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int n;
        clk                = 1'b0;
        rst_n              = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = OP_FIRST;
        in_bus.coefficient = '0;
        in_bus.last        = 1'b0;
        out_bus.ready      = 1'b0;
        first_len          = 0;
        second_len         = 0;
        first_closed       = 1'b0;
        lost_terms         = 1'b0;
        words_taken        = 0;
        bad_results        = 0;
        quiet_cycles       = 0;

        // positive and negative clipping of single terms
        push_word(OP_FIRST,  32'h7FFF_FFFF, 1'b1);
        push_word(OP_SECOND, 32'h7FFF_FFFF, 1'b1);
        push_word(OP_FIRST,  32'h8000_0000, 1'b1);
        push_word(OP_SECOND, 32'h7FFF_FFFF, 1'b1);
        push_word(OP_FIRST,  32'h8000_0000, 1'b1);
        push_word(OP_SECOND, 32'h8000_0000, 1'b1);
        // empty first polynomial: all-zero product
        push_word(OP_SECOND, 32'h0000_0005, 1'b0);
        push_word(OP_SECOND, 32'h0001_0000, 1'b1);
        // second words before the first polynomial ends
        push_word(OP_FIRST,  32'h0001_0000, 1'b0);
        push_word(OP_SECOND, 32'h0002_0000, 1'b0);
        push_word(OP_SECOND, 32'hFFFF_0000, 1'b1);
        // first polynomial resent after it was closed
        push_word(OP_FIRST,  32'h0001_0000, 1'b1);
        push_word(OP_FIRST,  32'h0002_0000, 1'b0);
        push_word(OP_FIRST,  32'hFFFF_0000, 1'b1);
        push_word(OP_SECOND, 32'h0003_0000, 1'b1);
        // floor on a negative fraction
        push_word(OP_FIRST,  32'hFFFF_FFFF, 1'b1);
        push_word(OP_SECOND, 32'h0000_0001, 1'b1);
        // zeros
        push_word(OP_FIRST,  32'h0000_0000, 1'b0);
        push_word(OP_FIRST,  32'h0000_0000, 1'b1);
        push_word(OP_SECOND, 32'h0000_0000, 1'b1);

        n = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < n) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                if ($urandom_range(9) != 0) push_poly(OP_FIRST, rand_len(), 1'b1);
                push_poly(OP_SECOND, rand_len(), 1'b1);
            end else if (kind < 78) begin
                push_poly(OP_FIRST, rand_len(), 1'b1);
                push_poly(OP_FIRST, rand_len(), 1'b1);
                push_poly(OP_SECOND, rand_len(), 1'b1);
            end else if (kind < 90) begin
                push_poly(OP_FIRST, $urandom_range(4, 1), 1'b0);
                push_poly(OP_SECOND, rand_len(), 1'b1);
            end else begin
                // noise: random marks on both polynomials
                repeat ($urandom_range(4, 1))
                    push_word(logic'($urandom_range(1)), rand_coef(), logic'($urandom_range(1)));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_bus.valid || expected_terms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/pm_pkg.sv
src/pm_ifs.sv
src/pm_cell.sv
src/polynomial_multiply.sv
sim/tb.sv
